FILE: hw/rtl/drc_pkg.sv
// Package for the distance repetition counter.
// Holds phase, beep and command codes, register indexes and the config struct.
// No dependencies.
package drc_pkg;

   localparam int DATA_W          = 16;
   localparam int ABSENCE_DEFAULT = 20;
   localparam int STABLE_DEFAULT  = 2;
   localparam int BOTTOM_MM       = 100;

   localparam logic [DATA_W-1:0] LOW_RESET    = 16'd50;
   localparam logic [DATA_W-1:0] HIGH_RESET   = 16'd200;
   localparam logic [DATA_W-1:0] TARGET_RESET = 16'd10;

   typedef enum logic [3:0] {
      PH_UP         = 4'b0001,
      PH_GOING_DOWN = 4'b0010,
      PH_DOWN       = 4'b0100,
      PH_COMING_UP  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      BEEP_NONE  = 2'd0,
      BEEP_SHORT = 2'd1,
      BEEP_LONG  = 2'd2
   } beep_type;

   typedef enum logic [1:0] {
      REG_LOW    = 2'd0,
      REG_HIGH   = 2'd1,
      REG_TARGET = 2'd2
   } reg_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } command_type;

   typedef struct packed {
      logic [DATA_W-1:0] low_threshold;
      logic [DATA_W-1:0] high_threshold;
      logic [DATA_W-1:0] target_reps;
   } cfg_type;

endpackage

FILE: hw/rtl/drc_step.sv
// Next-state logic of the repetition counter for one transaction.
// Pure combinational; depends on drc_pkg.
module drc_step import drc_pkg::*; #(
   parameter int ABSENCE_READS = ABSENCE_DEFAULT,
   parameter int STABLE_READS  = STABLE_DEFAULT,
   parameter int ABS_W         = $clog2(ABSENCE_READS + 1),
   parameter int STB_W         = $clog2(STABLE_READS + 1)
) (
   input  cfg_type           cfg,
   input  command_type       command,
   input  logic [DATA_W-1:0] distance_mm,
   input  phase_type         phase,
   input  logic [DATA_W-1:0] reps,
   input  logic [DATA_W-1:0] last_distance,
   input  logic [STB_W-1:0]  stable_reads,
   input  logic [ABS_W-1:0]  absent_reads,
   output phase_type         phase_in,
   output logic [DATA_W-1:0] reps_in,
   output logic [DATA_W-1:0] last_distance_in,
   output logic [STB_W-1:0]  stable_reads_in,
   output logic [ABS_W-1:0]  absent_reads_in,
   output beep_type          beep
);

   localparam logic [ABS_W-1:0] ABS_MAX = ABS_W'(ABSENCE_READS);
   localparam logic [STB_W-1:0] STB_MAX = STB_W'(STABLE_READS);
   localparam logic [DATA_W-1:0] BOTTOM = DATA_W'(BOTTOM_MM);

   logic              is_low;
   logic              is_high;
   logic [DATA_W:0]   reps_inc;

   assign is_low   = distance_mm <= cfg.low_threshold;
   assign is_high  = distance_mm >= cfg.high_threshold;
   assign reps_inc = {1'b0, reps} + 1'b1;

   always_comb begin
      phase_in         = phase;
      reps_in          = reps;
      last_distance_in = last_distance;
      stable_reads_in  = stable_reads;
      absent_reads_in  = absent_reads;
      beep             = BEEP_NONE;
      if (command == CMD_CLEAR) begin
         reps_in = '0;
      end else if (distance_mm == '0) begin
         if (absent_reads < ABS_MAX) begin
            absent_reads_in = absent_reads + 1'b1;
         end
         if (absent_reads_in >= ABS_MAX) begin
            phase_in        = PH_UP;
            stable_reads_in = '0;
         end
      end else begin
         absent_reads_in  = '0;
         last_distance_in = distance_mm;
         case (phase)
            PH_UP: begin
               if (is_low) phase_in = PH_GOING_DOWN;
            end
            PH_GOING_DOWN: begin
               if (is_low) begin
                  if (distance_mm <= BOTTOM) phase_in = PH_DOWN;
               end else if (distance_mm > cfg.high_threshold) begin
                  phase_in = PH_UP;
               end
            end
            PH_DOWN: begin
               if (is_high) phase_in = PH_COMING_UP;
            end
            default: begin
               if (is_high) begin
                  if (distance_mm == last_distance) begin
                     stable_reads_in = stable_reads + 1'b1;
                     if (stable_reads_in >= STB_MAX) begin
                        if (reps_inc >= {1'b0, cfg.target_reps}) begin
                           reps_in = cfg.target_reps;
                           beep    = BEEP_LONG;
                        end else begin
                           reps_in = reps_inc[DATA_W-1:0];
                           beep    = BEEP_SHORT;
                        end
                        phase_in        = PH_UP;
                        stable_reads_in = '0;
                     end
                  end else begin
                     stable_reads_in = '0;
                  end
               end else if (is_low) begin
                  phase_in        = PH_DOWN;
                  stable_reads_in = '0;
               end
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/distance_repetition_counter.sv
// Top level of the distance repetition counter: handshakes, state and config registers.
// Depends on drc_pkg and drc_step.
//
//   channel | direction | payload
//   req     | in        | tuser: command; tdata: distance_mm
//   rsp     | out       | tdata: rep_count, beep
//   csr     | in        | index, data (write only, always ready)
//
// One transaction per cycle unless stalled; the result is registered on acceptance.
// All the step logic sits between the request port and the state/result registers.
// Reset sets the up phase, clears counters and count, and loads the register defaults.
// A stalled result holds; a new request is taken in the cycle the result is taken.
module distance_repetition_counter import drc_pkg::*; #(
   parameter int ABSENCE_READS = ABSENCE_DEFAULT,
   parameter int STABLE_READS  = STABLE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] distance_mm
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] rep_count, [17:16] beep, [23:18] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int ABS_W = $clog2(ABSENCE_READS + 1);
   localparam int STB_W = $clog2(STABLE_READS + 1);

   cfg_type           cfg_ff;
   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] reps_ff, reps_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [STB_W-1:0]  stable_ff, stable_in;
   logic [ABS_W-1:0]  absent_ff, absent_in;
   beep_type          beep;
   logic              rsp_valid_ff;
   logic [23:0]       rsp_data_ff;
   logic              accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   drc_step #(
      .ABSENCE_READS (ABSENCE_READS),
      .STABLE_READS  (STABLE_READS),
      .ABS_W         (ABS_W),
      .STB_W         (STB_W)
   ) u_step (
      .cfg              (cfg_ff),
      .command          (command_type'(req_tuser)),
      .distance_mm      (req_tdata),
      .phase            (phase_ff),
      .reps             (reps_ff),
      .last_distance    (last_ff),
      .stable_reads     (stable_ff),
      .absent_reads     (absent_ff),
      .phase_in         (phase_in),
      .reps_in          (reps_in),
      .last_distance_in (last_in),
      .stable_reads_in  (stable_in),
      .absent_reads_in  (absent_in),
      .beep             (beep)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= LOW_RESET;
         cfg_ff.high_threshold <= HIGH_RESET;
         cfg_ff.target_reps    <= TARGET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_LOW:    cfg_ff.low_threshold  <= csr_data;
            REG_HIGH:   cfg_ff.high_threshold <= csr_data;
            REG_TARGET: cfg_ff.target_reps    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_UP;
         reps_ff      <= '0;
         last_ff      <= '0;
         stable_ff    <= '0;
         absent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            reps_ff   <= reps_in;
            last_ff   <= last_in;
            stable_ff <= stable_in;
            absent_ff <= absent_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {6'd0, beep, reps_in};
      end
   end

`ifndef SYNTHESIS
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   a_absent_sat: assert property (@(posedge clock) disable iff (reset)
      absent_ff <= ABS_W'(ABSENCE_READS))
      else $error("absence counter beyond saturation");

   a_stable_range: assert property (@(posedge clock) disable iff (reset)
      stable_ff < STB_W'(STABLE_READS))
      else $error("stable counter not cleared on rep");

   a_long_beep_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[17:16] == BEEP_LONG)
      |-> rsp_data_ff[15:0] == cfg_ff.target_reps)
      else $error("long beep without count at target");

   a_rep_ends_up: assert property (@(posedge clock) disable iff (reset)
      accept && (beep != BEEP_NONE) |=> phase_ff == PH_UP)
      else $error("confirmed rep did not return to up phase");
`endif

endmodule
